/* src/tty_output_post_processing_unit_assert.svh */
`ifndef TTY_OUTPUT_POST_PROCESSING_UNIT_ASSERT_SVH
`define TTY_OUTPUT_POST_PROCESSING_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TOPP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("topp assertion failed");

// next-cycle implication, checked out of reset
`define TOPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("topp assertion failed");

`endif

/* src/topp_pkg.sv */
package topp_pkg;

  localparam int unsigned TAB_WIDTH   = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned TAB_BITS    = $clog2(TAB_WIDTH);
  localparam int unsigned STEP_W      = $clog2(TAB_WIDTH + 1);
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] CR_DLY_SHORT = 8'd80;
  localparam logic [7:0] CR_DLY_LONG  = 8'd160;
  localparam logic [7:0] NL_DLY_SHORT = 8'd10;
  localparam logic [7:0] NL_DLY_LONG  = 8'd100;

  typedef enum logic [2:0] {
    REG_RAW_MODE      = 3'd0,
    REG_MAP_NEWLINE   = 3'd1,
    REG_EXPAND_TABS   = 3'd2,
    REG_CR_DELAY_MODE = 3'd3,
    REG_NL_DELAY_MODE = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    DLY_NONE  = 2'd0,
    DLY_SHORT = 2'd1,
    DLY_LONG  = 2'd2
  } dly_mode_e;

  typedef struct packed {
    logic       raw_mode;
    logic       map_newline;
    logic       expand_tabs;
    logic [1:0] cr_delay_mode;
    logic [1:0] nl_delay_mode;
  } cfg_t;

  // one decoded byte: head result, then cnt-1 copies of the tail result
  typedef struct packed {
    logic [7:0]       head_char;
    logic [7:0]       head_delay;
    logic [7:0]       tail_char;
    logic [7:0]       tail_delay;
    logic [CNT_W-1:0] cnt;
  } job_t;

  function automatic logic [7:0] cr_delay(input logic [1:0] mode);
    logic [7:0] d;
    case (mode)
      DLY_SHORT: d = CR_DLY_SHORT;
      DLY_LONG:  d = CR_DLY_LONG;
      default:   d = 8'd0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] nl_delay(input logic [1:0] mode);
    logic [7:0] d;
    case (mode)
      DLY_SHORT: d = NL_DLY_SHORT;
      DLY_LONG:  d = NL_DLY_LONG;
      default:   d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

/* src/topp_decode.sv */
module topp_decode import topp_pkg::*; (
  input  logic [7:0]  char_i,
  input  cfg_t        cfg_i,
  input  logic [7:0]  column_i,
  output job_t        job_o,
  output logic [7:0]  column_o,
  output logic        line_inc_o
);

  logic [TAB_BITS-1:0] tab_rem;
  logic [STEP_W-1:0]   tab_step;

  // distance to the next tab stop, 1..TAB_WIDTH
  assign tab_rem  = column_i[TAB_BITS-1:0];
  assign tab_step = STEP_W'(TAB_WIDTH) - STEP_W'(tab_rem);

  always_comb begin
    job_o.head_char  = char_i;
    job_o.head_delay = 8'd0;
    job_o.tail_char  = char_i;
    job_o.tail_delay = 8'd0;
    job_o.cnt        = CNT_W'(1);
    column_o         = column_i + 8'd1;
    line_inc_o       = 1'b0;
    if (!cfg_i.raw_mode) begin
      case (char_i)
        CH_TAB: begin
          column_o = column_i + 8'(tab_step);
          if (cfg_i.expand_tabs) begin
            job_o.head_char = CH_SPACE;
            job_o.tail_char = CH_SPACE;
            if (tab_step > STEP_W'(MAX_RESULTS)) begin
              job_o.cnt = CNT_W'(MAX_RESULTS);
            end else begin
              job_o.cnt = CNT_W'(tab_step);
            end
          end
        end
        CH_BS: begin
          column_o = (column_i == 8'd0) ? 8'd0 : column_i - 8'd1;
        end
        CH_NL: begin
          job_o.head_delay = nl_delay(cfg_i.nl_delay_mode);
          line_inc_o       = 1'b1;
          column_o         = column_i;
          if (cfg_i.map_newline) begin
            job_o.tail_char  = CH_CR;
            job_o.tail_delay = cr_delay(cfg_i.cr_delay_mode);
            job_o.cnt        = CNT_W'(2);
            column_o         = 8'd0;
          end
        end
        CH_CR: begin
          job_o.head_delay = cr_delay(cfg_i.cr_delay_mode);
          column_o         = 8'd0;
        end
        default: begin
          column_o = column_i + 8'd1;
        end
      endcase
    end
  end

endmodule

/* src/tty_output_post_processing_unit.sv */
// Terminal output post-processor: takes one byte per request from the transmit
// queue and emits the device bytes for it, one per output request, keeping a
// column and a line count. A byte is decoded into a short job (one result,
// newline followed by carriage return, or up to eight spaces for an expanded
// tab) held in an input register, and its results leave from an output
// register, so its first result passes through both registers. While the
// receiver keeps up, a new byte is taken every cycle if each yields one
// result, and the output register sends one byte per cycle; a byte with
// several results stalls the input until its final result moves to the
// output register. last_o marks the final result of each input byte and
// delay_ms_o is the wait the device owes after a newline or carriage return.
// The user must write configuration through the cfg port only while the block
// is idle; the block does not enforce this. The cfg port is always ready.
module tty_output_post_processing_unit import topp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input byte channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  // device byte channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [7:0] delay_ms_o,
  output logic       last_o,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t        cfg_q, cfg_d;
  logic [7:0]  column_q, column_d;
  logic [15:0] line_q, line_d;

  logic        job_valid_q, job_valid_d;
  job_t        job_q, job_d;
  job_t        dec_job;
  logic [7:0]  dec_column;
  logic        dec_line_inc;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q, out_char_d;
  logic [7:0]  out_delay_q, out_delay_d;
  logic        out_last_q, out_last_d;

  logic        out_free;
  logic        job_take;
  logic        job_done;
  logic        in_fire;

  // output register can load when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  assign job_take = job_valid_q && out_free;
  // job register frees when its final result moves to the output register
  assign job_done = job_take && (job_q.cnt == CNT_W'(1));

  assign in_stall_o = job_valid_q && !job_done;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  topp_decode u_decode (
    .char_i     (in_char_i),
    .cfg_i      (cfg_q),
    .column_i   (column_q),
    .job_o      (dec_job),
    .column_o   (dec_column),
    .line_inc_o (dec_line_inc)
  );

  // configuration registers, values masked to their width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RAW_MODE:      cfg_d.raw_mode      = cfg_data_i[0];
        REG_MAP_NEWLINE:   cfg_d.map_newline   = cfg_data_i[0];
        REG_EXPAND_TABS:   cfg_d.expand_tabs   = cfg_data_i[0];
        REG_CR_DELAY_MODE: cfg_d.cr_delay_mode = cfg_data_i[1:0];
        REG_NL_DELAY_MODE: cfg_d.nl_delay_mode = cfg_data_i[1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // column and line count follow each accepted byte
  always_comb begin
    column_d = column_q;
    line_d   = line_q;
    if (in_fire) begin
      column_d = dec_column;
      line_d   = line_q + 16'(dec_line_inc);
    end
  end

  // job register: load a decoded byte, or step to the tail result
  always_comb begin
    job_valid_d = job_valid_q;
    job_d       = job_q;
    if (in_fire) begin
      job_valid_d = 1'b1;
      job_d       = dec_job;
    end else if (job_done) begin
      job_valid_d = 1'b0;
    end else if (job_take) begin
      job_d.head_char  = job_q.tail_char;
      job_d.head_delay = job_q.tail_delay;
      job_d.cnt        = job_q.cnt - CNT_W'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_delay_d = out_delay_q;
    out_last_d  = out_last_q;
    if (out_free) begin
      out_valid_d = job_valid_q;
      out_char_d  = job_q.head_char;
      out_delay_d = job_q.head_delay;
      out_last_d  = (job_q.cnt == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{raw_mode: 1'b0, map_newline: 1'b1, expand_tabs: 1'b0,
                       cr_delay_mode: DLY_NONE, nl_delay_mode: DLY_NONE};
      column_q    <= 8'd0;
      line_q      <= 16'd0;
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      column_q    <= column_d;
      line_q      <= line_d;
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    out_char_q  <= out_char_d;
    out_delay_q <= out_delay_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign delay_ms_o  = out_delay_q;
  assign last_o      = out_last_q;

`include "tty_output_post_processing_unit_assert.svh"

  // a held job always has results left to send
  `TOPP_ASSERT_SAME(a_job_cnt_nonzero, job_valid_q, job_q.cnt != CNT_W'(0))
  // a byte is taken over a busy job only as that job hands over its last result
  `TOPP_ASSERT_SAME(a_in_only_on_done, in_fire && job_valid_q,
                    out_free && job_q.cnt == CNT_W'(1))
  // a non-final result taken is followed straight away by the next one
  `TOPP_ASSERT_NEXT(a_no_gap_in_item, out_valid_q && !out_stall_i && !out_last_q,
                    out_valid_q)
  // carriage return in cooked mode clears the column
  `TOPP_ASSERT_NEXT(a_cr_clears_column, in_fire && !cfg_q.raw_mode && in_char_i == CH_CR,
                    column_q == 8'd0)

endmodule

/* tb/sv/tty_output_post_processing_unit_tb.sv */
module tty_output_post_processing_unit_tb;
  import topp_pkg::*;

  // clocking, reset and run length
  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned IDLE_PERCENT = 31;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_BYTES  = 18;

  // highest index the cfg port can carry; anything above the list is ignored
  localparam logic [2:0] REG_INDEX_TOP = 3'd7;

  // one device byte as the output channel delivers it
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] dly;
    logic       last;
  } device_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic [7:0] delay_ms_o;
  logic       last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  // shadow of the block's registers and state
  cfg_t        shadow_cfg;
  logic [7:0]  tx_column;
  logic [15:0] tx_line_count;

  // device bytes still owed by the block, oldest first
  device_byte_t expected_device_bytes[$];

  int unsigned mismatch_count;
  bit          in_gaps_on;
  bit          out_gaps_on;
  int unsigned hold_off_left;

  tty_output_post_processing_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_char_i   (in_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .delay_ms_o  (delay_ms_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // free-running clock, period 8
  initial clk_i = 1'b0;
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // wait owed after a newline or carriage return, by delay code
  function automatic logic [7:0] wait_after(input logic [7:0] ch, input logic [1:0] mode);
    logic [7:0] short_ms;
    logic [7:0] long_ms;
    short_ms = (ch == CH_CR) ? CR_DLY_SHORT : NL_DLY_SHORT;
    long_ms  = (ch == CH_CR) ? CR_DLY_LONG : NL_DLY_LONG;
    if (mode == DLY_SHORT) return short_ms;
    if (mode == DLY_LONG) return long_ms;
    // unused code gives no delay
    return 8'd0;
  endfunction

  // works out the device bytes for one accepted byte and advances the shadow state
  function automatic void predict_device_bytes(input logic [7:0] c);
    device_byte_t burst[$];
    int unsigned  step;
    int unsigned  count;
    if (shadow_cfg.raw_mode) begin
      burst.push_back('{c, 8'd0, 1'b0});
      tx_column = tx_column + 8'd1;
    end else begin
      case (c)
        CH_TAB: begin
          // next tab stop; the column wraps past 255
          step      = ((tx_column + TAB_WIDTH) / TAB_WIDTH) * TAB_WIDTH - tx_column;
          tx_column = 8'(tx_column + step);
          if (shadow_cfg.expand_tabs) begin
            count = (step > MAX_RESULTS) ? MAX_RESULTS : step;
            for (int unsigned i = 0; i < count; i++) burst.push_back('{CH_SPACE, 8'd0, 1'b0});
          end else begin
            burst.push_back('{c, 8'd0, 1'b0});
          end
        end
        CH_BS: begin
          // clamps at column zero
          burst.push_back('{c, 8'd0, 1'b0});
          if (tx_column != 8'd0) tx_column = tx_column - 8'd1;
        end
        CH_NL: begin
          burst.push_back('{CH_NL, wait_after(CH_NL, shadow_cfg.nl_delay_mode), 1'b0});
          tx_line_count = tx_line_count + 16'd1;
          if (shadow_cfg.map_newline) begin
            burst.push_back('{CH_CR, wait_after(CH_CR, shadow_cfg.cr_delay_mode), 1'b0});
            tx_column = 8'd0;
          end
        end
        CH_CR: begin
          burst.push_back('{CH_CR, wait_after(CH_CR, shadow_cfg.cr_delay_mode), 1'b0});
          tx_column = 8'd0;
        end
        default: begin
          burst.push_back('{c, 8'd0, 1'b0});
          tx_column = tx_column + 8'd1;
        end
      endcase
    end
    burst[$].last = 1'b1;
    foreach (burst[i]) expected_device_bytes.push_back(burst[i]);
  endfunction

  // byte mix that favours the control characters
  function automatic logic [7:0] pick_tx_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return CH_TAB;
    if (r < 18) return CH_NL;
    if (r < 25) return CH_CR;
    if (r < 31) return CH_BS;
    return 8'($urandom_range(255));
  endfunction

  function automatic void check_field(input string field, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // offers one byte and waits for its request to be taken
  task automatic send_tx_byte(input logic [7:0] c);
    @(negedge clk_i);
    while (in_gaps_on && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_device_bytes(c);
  endtask

  // drops the input request and waits until every owed byte has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_device_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, only ever with the block idle
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_RAW_MODE:      shadow_cfg.raw_mode      = data[0];
      REG_MAP_NEWLINE:   shadow_cfg.map_newline   = data[0];
      REG_EXPAND_TABS:   shadow_cfg.expand_tabs   = data[0];
      REG_CR_DELAY_MODE: shadow_cfg.cr_delay_mode = data[1:0];
      REG_NL_DELAY_MODE: shadow_cfg.nl_delay_mode = data[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] raw, input logic [7:0] map_nl,
                                input logic [7:0] expand, input logic [7:0] cr_mode,
                                input logic [7:0] nl_mode);
    write_reg(REG_RAW_MODE, raw);
    write_reg(REG_MAP_NEWLINE, map_nl);
    write_reg(REG_EXPAND_TABS, expand);
    write_reg(REG_CR_DELAY_MODE, cr_mode);
    write_reg(REG_NL_DELAY_MODE, nl_mode);
  endtask

  // field extremes, every character class and each mode from reset onwards
  task automatic test_directed_bytes();
    // reset settings: cooked, newline mapped, tabs kept, no delays
    send_tx_byte(8'h00);
    send_tx_byte(8'hFF);
    send_tx_byte("A");
    send_tx_byte(CH_CR);
    // backspace at column zero must not wrap, tab then steps a full eight
    send_tx_byte(CH_BS);
    send_tx_byte(CH_TAB);
    write_reg(REG_EXPAND_TABS, 8'd1);
    send_tx_byte(CH_CR);
    send_tx_byte(CH_TAB);
    send_tx_byte("x");
    send_tx_byte(CH_TAB);
    send_tx_byte(CH_BS);
    send_tx_byte(CH_BS);
    send_tx_byte(CH_TAB);
    send_tx_byte(CH_NL);
    // every delay code, the unused one included
    apply_settings(8'd0, 8'd1, 8'd1, 8'(DLY_SHORT), 8'(DLY_SHORT));
    send_tx_byte(CH_NL);
    send_tx_byte(CH_CR);
    apply_settings(8'd0, 8'd1, 8'd1, 8'(DLY_LONG), 8'(DLY_LONG));
    send_tx_byte(CH_NL);
    apply_settings(8'd0, 8'd1, 8'd1, 8'd3, 8'd3);
    send_tx_byte(CH_NL);
    // newline without carriage return
    write_reg(REG_MAP_NEWLINE, 8'd0);
    send_tx_byte(CH_NL);
    // raw mode passes control characters untouched
    write_reg(REG_RAW_MODE, 8'd1);
    send_tx_byte(CH_TAB);
    send_tx_byte(CH_NL);
    send_tx_byte(CH_CR);
    send_tx_byte(CH_BS);
  endtask

  // walks the column past 255, once with a tab step crossing the wrap
  task automatic test_column_wrap();
    apply_settings(8'd0, 8'd1, 8'd0, 8'(DLY_NONE), 8'(DLY_NONE));
    send_tx_byte(CH_CR);
    repeat (31) send_tx_byte(CH_TAB);
    repeat (3) send_tx_byte("a");
    write_reg(REG_EXPAND_TABS, 8'd1);
    send_tx_byte(CH_TAB);
    send_tx_byte(CH_TAB);
    send_tx_byte("b");
  endtask

  // writes to indexes past the list must leave the settings alone
  task automatic test_unused_reg_index();
    apply_settings(8'd0, 8'd1, 8'd1, 8'(DLY_SHORT), 8'(DLY_LONG));
    for (int i = REG_NL_DELAY_MODE + 1; i <= REG_INDEX_TOP; i++) write_reg(3'(i), 8'($urandom));
    send_tx_byte(CH_NL);
    send_tx_byte(CH_TAB);
    send_tx_byte(CH_CR);
    send_tx_byte("z");
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_hold_off();
    apply_settings(8'd0, 8'd1, 8'd1, 8'(DLY_LONG), 8'(DLY_SHORT));
    in_gaps_on    = 1'b0;
    hold_off_left = HOLD_CYCLES;
    repeat (24) send_tx_byte(pick_tx_byte());
    wait_drained();
    in_gaps_on = 1'b1;
  endtask

  // random bytes under a spread of settings
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(8'd0, 8'd0, 8'd0, 8'(DLY_NONE), 8'(DLY_NONE));
        1: apply_settings(8'd0, 8'd1, 8'd1, 8'(DLY_LONG), 8'(DLY_LONG));
        2: apply_settings(8'd1, 8'd1, 8'd1, 8'(DLY_LONG), 8'(DLY_LONG));
        default: apply_settings(8'd0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // one phase runs flat out on both sides
      in_gaps_on  = (phase != 4);
      out_gaps_on = (phase != 4);
      repeat (PHASE_BYTES) send_tx_byte(pick_tx_byte());
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // receiver side: random stall, or a counted hold-off when one is asked for
  always @(negedge clk_i) begin
    if (hold_off_left != 0) begin
      out_stall_i   <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall_i <= out_gaps_on && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // every accepted device byte against the oldest one owed
  always @(posedge clk_i) begin
    device_byte_t owed;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_device_bytes.size() == 0) begin
        $error("device byte %0d with nothing expected", out_char_o);
        mismatch_count++;
      end else begin
        owed = expected_device_bytes.pop_front();
        check_field("out_char", owed.ch, out_char_o);
        check_field("delay_ms", owed.dly, delay_ms_o);
        check_field("last", {7'd0, owed.last}, {7'd0, last_o});
      end
    end
  end

  initial begin
    // everything driven and the shadow at its reset values from time zero
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_char_i     = 8'd0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = 3'd0;
    cfg_data_i    = 8'd0;
    shadow_cfg    = '{raw_mode: 1'b0, map_newline: 1'b1, expand_tabs: 1'b0,
                      cr_delay_mode: DLY_NONE, nl_delay_mode: DLY_NONE};
    tx_column     = 8'd0;
    tx_line_count = 16'd0;
    mismatch_count = 0;
    in_gaps_on    = 1'b1;
    out_gaps_on   = 1'b1;
    hold_off_left = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_bytes();
    test_column_wrap();
    test_unused_reg_index();
    test_output_hold_off();
    test_random_traffic();

    // let anything stray come out before judging
    wait_drained();
    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[tty_output_post_processing_unit] OK");
    end else begin
      $display("[tty_output_post_processing_unit] ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("[tty_output_post_processing_unit] ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/topp_pkg.sv
src/topp_decode.sv
src/tty_output_post_processing_unit.sv
tb/sv/tty_output_post_processing_unit_tb.sv
